// ===== sv/alc_pkg.sv =====
package alc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int WEIGHT_BITS = 16;
    localparam int TIME_BITS   = 64;
    localparam int IDX_BITS    = 12;
    localparam int PERIOD_BITS = 30;
    localparam int OFF_BITS    = IDX_BITS + PERIOD_BITS;
    localparam int W_BITS      = WEIGHT_BITS + 1;
    localparam int Q_BITS      = WEIGHT_BITS + 1;
    localparam int REM_BITS    = TIME_BITS - 1;
    localparam int PROD_BITS   = SAMPLE_BITS + W_BITS + 1;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
    localparam logic [W_BITS-1:0] W_ONE = W_BITS'(1) << WEIGHT_BITS;
    localparam logic signed [PROD_BITS-1:0] MIX_HALF = PROD_BITS'(1) << (WEIGHT_BITS - 1);
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14700);

    localparam logic [CFG_IDX_BITS-1:0] CFG_START  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD = CFG_IDX_BITS'(2);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [W_BITS-1:0] t_weight;

    typedef enum logic [1:0] {
        W_ZERO = 2'd0,
        W_FULL = 2'd1,
        W_DIV  = 2'd2
    } t_wsel;

    typedef struct packed {
        t_wsel                 sel;
        logic [REM_BITS-1:0]   elapsed;
        t_sample               from_s;
        t_sample               to_s;
    } t_tm_item;

    typedef struct packed {
        t_weight w;
        t_weight wc;
        t_sample from_s;
        t_sample to_s;
    } t_dv_item;

endpackage

// ===== sv/alc_time.sv =====
module alc_time import alc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [TIME_BITS-1:0]   i_start_time,
    input  logic [TIME_BITS-1:0]   i_fade_length,
    input  logic [PERIOD_BITS-1:0] i_frame_period,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [TIME_BITS-1:0]   i_window_start,
    input  logic [IDX_BITS-1:0]    i_frame_index,
    input  t_sample                i_sample_from,
    input  t_sample                i_sample_to,
    input  logic                   i_from_present,
    input  logic                   i_to_present,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_tm_item               o_item
);

    logic                 r_a_v, r_b_v, r_c_v, r_d_v;
    logic [TIME_BITS-1:0] r_a_ws;
    logic [OFF_BITS-1:0]  r_a_off;
    t_sample              r_a_from, r_a_to, r_b_from, r_b_to, r_c_from, r_c_to;
    logic [TIME_BITS-1:0] r_b_t, n_b_t;
    logic [TIME_BITS:0]   r_c_diff;
    t_tm_item             r_d_item, n_d_item;

    logic a_adv, b_adv, c_adv, d_adv;
    logic [TIME_BITS:0] b_sum;
    logic d_neg, d_fade_pos;
    logic [TIME_BITS-1:0] d_elapsed;

    assign d_adv   = !r_d_v || i_ready;
    assign c_adv   = !r_c_v || d_adv;
    assign b_adv   = !r_b_v || c_adv;
    assign a_adv   = !r_a_v || b_adv;
    assign o_ready = a_adv;

    always_comb begin
        b_sum = {r_a_ws[TIME_BITS-1], r_a_ws} + (TIME_BITS+1)'(r_a_off);
        if (!b_sum[TIME_BITS] && b_sum[TIME_BITS-1]) begin
            n_b_t = TIME_MAX;
        end else begin
            n_b_t = b_sum[TIME_BITS-1:0];
        end
    end

    always_comb begin
        d_neg      = r_c_diff[TIME_BITS];
        d_elapsed  = r_c_diff[TIME_BITS-1:0];
        d_fade_pos = !i_fade_length[TIME_BITS-1] && (|i_fade_length);
        n_d_item.elapsed = d_elapsed[REM_BITS-1:0];
        n_d_item.from_s  = r_c_from;
        n_d_item.to_s    = r_c_to;
        if (d_neg) begin
            n_d_item.sel = W_ZERO;
        end else if (!d_fade_pos) begin
            n_d_item.sel = W_FULL;
        end else if (d_elapsed >= i_fade_length) begin
            n_d_item.sel = W_FULL;
        end else begin
            n_d_item.sel = W_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (a_adv) r_a_v <= i_valid;
            if (b_adv) r_b_v <= r_a_v;
            if (c_adv) r_c_v <= r_b_v;
            if (d_adv) r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_a_ws   <= i_window_start;
            r_a_off  <= OFF_BITS'(i_frame_index) * OFF_BITS'(i_frame_period);
            r_a_from <= i_from_present ? i_sample_from : '0;
            r_a_to   <= i_to_present ? i_sample_to : '0;
        end
        if (b_adv) begin
            r_b_t    <= n_b_t;
            r_b_from <= r_a_from;
            r_b_to   <= r_a_to;
        end
        if (c_adv) begin
            r_c_diff <= {r_b_t[TIME_BITS-1], r_b_t}
                      - {i_start_time[TIME_BITS-1], i_start_time};
            r_c_from <= r_b_from;
            r_c_to   <= r_b_to;
        end
        if (d_adv) begin
            r_d_item <= n_d_item;
        end
    end

    assign o_valid = r_d_v;
    assign o_item  = r_d_item;

endmodule

// ===== sv/alc_div.sv =====
module alc_div import alc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [TIME_BITS-1:0] i_fade_length,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_tm_item             i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_dv_item             o_item
);

    logic                r_v    [Q_BITS];
    logic [REM_BITS-1:0] r_rem  [Q_BITS];
    logic [Q_BITS-1:0]   r_q    [Q_BITS];
    t_wsel               r_sel  [Q_BITS];
    t_sample             r_from [Q_BITS];
    t_sample             r_to   [Q_BITS];
    logic                r_o_v;
    t_dv_item            r_o_item, n_o_item;

    logic                s_v    [Q_BITS+1];
    logic [REM_BITS-1:0] s_rem  [Q_BITS+1];
    logic [Q_BITS-1:0]   s_q    [Q_BITS+1];
    t_wsel               s_sel  [Q_BITS+1];
    t_sample             s_from [Q_BITS+1];
    t_sample             s_to   [Q_BITS+1];
    logic                adv    [Q_BITS+1];

    logic [REM_BITS-1:0] dur;
    logic [Q_BITS:0]     q_round;

    assign dur = i_fade_length[REM_BITS-1:0];

    assign s_v[0]    = i_valid;
    assign s_rem[0]  = i_item.elapsed;
    assign s_q[0]    = '0;
    assign s_sel[0]  = i_item.sel;
    assign s_from[0] = i_item.from_s;
    assign s_to[0]   = i_item.to_s;

    assign adv[Q_BITS] = !r_o_v || i_ready;
    assign o_ready     = adv[0];

    // one restoring step per stage, MSB of the quotient first
    for (genvar k = 0; k < Q_BITS; k++) begin : g_step
        logic [REM_BITS:0] r2;
        logic              ge;

        assign r2     = {s_rem[k], 1'b0};
        assign ge     = r2 >= {1'b0, dur};
        assign adv[k] = !r_v[k] || adv[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (adv[k]) begin
                r_v[k] <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[k]) begin
                r_rem[k]  <= ge ? REM_BITS'(r2 - {1'b0, dur}) : r2[REM_BITS-1:0];
                r_q[k]    <= {s_q[k][Q_BITS-2:0], ge};
                r_sel[k]  <= s_sel[k];
                r_from[k] <= s_from[k];
                r_to[k]   <= s_to[k];
            end
        end

        assign s_v[k+1]    = r_v[k];
        assign s_rem[k+1]  = r_rem[k];
        assign s_q[k+1]    = r_q[k];
        assign s_sel[k+1]  = r_sel[k];
        assign s_from[k+1] = r_from[k];
        assign s_to[k+1]   = r_to[k];
    end

    always_comb begin
        q_round = {1'b0, s_q[Q_BITS]} + (Q_BITS+1)'(1);
        case (s_sel[Q_BITS])
            W_ZERO:  n_o_item.w = '0;
            W_FULL:  n_o_item.w = W_ONE;
            W_DIV:   n_o_item.w = q_round[Q_BITS:1];
            default: n_o_item.w = '0;
        endcase
        n_o_item.wc     = W_ONE - n_o_item.w;
        n_o_item.from_s = s_from[Q_BITS];
        n_o_item.to_s   = s_to[Q_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (adv[Q_BITS]) begin
            r_o_v <= s_v[Q_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[Q_BITS]) begin
            r_o_item <= n_o_item;
        end
    end

    assign o_valid = r_o_v;
    assign o_item  = r_o_item;

endmodule

// ===== sv/alc_mix.sv =====
module alc_mix import alc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dv_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_sample  o_mixed_sample,
    output t_weight  o_weight_used
);

    logic                        r_m_v, r_o_v;
    logic signed [PROD_BITS-1:0] r_m_pf, r_m_pt;
    t_weight                     r_m_w, r_o_w;
    t_sample                     r_o_mixed;

    logic m_adv, o_adv;
    logic signed [PROD_BITS-1:0] o_sum;

    assign o_adv   = !r_o_v || i_ready;
    assign m_adv   = !r_m_v || o_adv;
    assign o_ready = m_adv;

    // rounding: add half, arithmetic shift gives floor, so ties go up
    assign o_sum = r_m_pf + r_m_pt + MIX_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (m_adv) r_m_v <= i_valid;
            if (o_adv) r_o_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_adv) begin
            r_m_pf <= i_item.from_s * $signed({1'b0, i_item.wc});
            r_m_pt <= i_item.to_s * $signed({1'b0, i_item.w});
            r_m_w  <= i_item.w;
        end
        if (o_adv) begin
            r_o_mixed <= o_sum[WEIGHT_BITS+SAMPLE_BITS-1:WEIGHT_BITS];
            r_o_w     <= r_m_w;
        end
    end

    assign o_valid        = r_o_v;
    assign o_mixed_sample = r_o_mixed;
    assign o_weight_used  = r_o_w;

endmodule

// ===== sv/audio_linear_crossfade.sv =====
// Linear audio crossfade: mixes one outgoing and one incoming sample per beat.
// Input channel (i_valid/o_ready): block start time, frame index, the two
// Q1.23 samples and their present flags. Output channel (o_valid/i_ready):
// the mixed Q1.23 sample and the incoming weight in Q1.16 (65536 = one).
// Config channel (i_cfg_valid/o_cfg_ready, never stalls): index 0 start
// time, 1 fade length, 2 frame period; write only while the pipeline is
// empty.
// The pipeline has 4 time stages (frame offset multiply, saturating add,
// difference, ramp compare), 17 restoring divide stages for the weight,
// one weight stage and 2 mix stages. Throughput is one beat per cycle
// while the receiver does not stall.
// Reset (synchronous, active low) empties the pipeline and loads start 0,
// fade length 0 and frame period 14700.
// When the receiver stalls, each stage holds its beat while empty stages
// upstream keep filling; o_ready drops only once every stage is occupied.
module audio_linear_crossfade import alc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [TIME_BITS-1:0]    i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [TIME_BITS-1:0]    i_window_start,
    input  logic [IDX_BITS-1:0]     i_frame_index,
    input  t_sample                 i_sample_from,
    input  t_sample                 i_sample_to,
    input  logic                    i_from_present,
    input  logic                    i_to_present,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_sample                 o_mixed_sample,
    output t_weight                 o_weight_used
);

    logic [TIME_BITS-1:0]   r_start_time, r_fade_length;
    logic [PERIOD_BITS-1:0] r_frame_period;

    logic     tm_valid, tm_ready, dv_valid, dv_ready;
    t_tm_item tm_item;
    t_dv_item dv_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time   <= '0;
            r_fade_length  <= '0;
            r_frame_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START:  r_start_time   <= i_cfg_data;
                CFG_LENGTH: r_fade_length  <= i_cfg_data;
                CFG_PERIOD: r_frame_period <= i_cfg_data[PERIOD_BITS-1:0];
                default: ;
            endcase
        end
    end

    alc_time u_time (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start_time   (r_start_time),
        .i_fade_length  (r_fade_length),
        .i_frame_period (r_frame_period),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_window_start (i_window_start),
        .i_frame_index  (i_frame_index),
        .i_sample_from  (i_sample_from),
        .i_sample_to    (i_sample_to),
        .i_from_present (i_from_present),
        .i_to_present   (i_to_present),
        .o_valid        (tm_valid),
        .i_ready        (tm_ready),
        .o_item         (tm_item)
    );

    alc_div u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fade_length (r_fade_length),
        .i_valid       (tm_valid),
        .o_ready       (tm_ready),
        .i_item        (tm_item),
        .o_valid       (dv_valid),
        .i_ready       (dv_ready),
        .o_item        (dv_item)
    );

    alc_mix u_mix (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (dv_valid),
        .o_ready        (dv_ready),
        .i_item         (dv_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mixed_sample (o_mixed_sample),
        .o_weight_used  (o_weight_used)
    );

endmodule

// ===== sv/alc_checker.sv =====
module alc_checker import alc_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    o_ready,
    input logic    o_valid,
    input logic    i_ready,
    input t_sample o_mixed_sample,
    input t_weight o_weight_used
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mixed_sample)
                                && $stable(o_weight_used))
        else $error("stalled output beat changed");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_weight_used <= W_ONE)
        else $error("weight above one");

    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled while output side drains");

endmodule

bind audio_linear_crossfade alc_checker u_alc_checker (.*);
